>>> rtl/core/tmcr_pkg.sv
// Shared types and constants for the thick midpoint circle rasterizer.
// No dependencies; every module of the block imports this package.
`default_nettype none

package tmcr_pkg;

  localparam int unsigned RADIUS_W  = 11;
  localparam int unsigned THICK_W   = 8;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned CFG_REG_W = 12;
  localparam int unsigned NPIX      = 8;

  // Register indexes of the write port
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Input word kinds
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam int unsigned SCREEN_WIDTH_RESET  = 240;
  localparam int unsigned SCREEN_HEIGHT_RESET = 320;

  // Of the eight octant slots with x = 0 and y = r, these hold the
  // four distinct axis pixels in ring-start order.
  localparam logic [NPIX-1:0] RING_AXIS_MASK = 8'b0011_0101;

  typedef struct packed {
    logic [NPIX-1:0] mask;  // candidates that survived clipping
    logic            fin;   // marker reports finished
  } tmcr_burst_t;

endpackage : tmcr_pkg

`default_nettype wire

>>> rtl/core/tmcr_engine.sv
// Circle state and one-pass candidate generation with screen clipping.
// Depends on tmcr_pkg.
`default_nettype none

module tmcr_engine import tmcr_pkg::*; #(
  parameter int unsigned CW = 12,
  parameter int unsigned AW = 15,
  parameter int unsigned DW = 18,
  parameter int unsigned SW = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic               kind_i,
  input  wire logic [CW-1:0]      center_x_i,
  input  wire logic [CW-1:0]      center_y_i,
  input  wire logic [RADIUS_W-1:0] radius_i,
  input  wire logic [THICK_W-1:0] thickness_i,
  input  wire logic [COLOR_W-1:0] color_i,
  input  wire logic [SW-1:0]      scr_w_i,
  input  wire logic [SW-1:0]      scr_h_i,
  output logic [CW-1:0]           px_o [NPIX],
  output logic [CW-1:0]           py_o [NPIX],
  output tmcr_burst_t             burst_o,
  output logic [COLOR_W-1:0]      color_o
);

  logic [CW-1:0]        ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d;
  logic [RADIUS_W-1:0]  rad_q, rad_d;
  logic [THICK_W-1:0]   idx_q, idx_d, tot_q, tot_d;
  logic signed [AW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [AW-1:0] dlx_q, dlx_d, dly_q, dly_d;
  logic signed [DW-1:0] dec_q, dec_d;
  logic                 busy_q, busy_d;
  logic [COLOR_W-1:0]   col_q, col_d;

  logic                 start, more_rings, begin_ring, do_step, fin;
  logic signed [AW-1:0] cx, cy, r_w, off_a, off_b, sy_t, dly_t;
  logic signed [DW-1:0] dec_t;
  logic [NPIX-1:0]      en, vis;
  logic signed [AW-1:0] xs [NPIX];
  logic signed [AW-1:0] ys [NPIX];

  always_comb begin
    start      = (kind_i == KIND_START);
    more_rings = ({1'b0, idx_q} + (THICK_W+1)'(1)) < {1'b0, tot_q};
    ctr_x_d    = ctr_x_q;
    ctr_y_d    = ctr_y_q;
    rad_d      = rad_q;
    idx_d      = idx_q;
    tot_d      = tot_q;
    col_d      = col_q;
    busy_d     = busy_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    dlx_d      = dlx_q;
    dly_d      = dly_q;
    dec_d      = dec_q;
    begin_ring = 1'b0;
    do_step    = 1'b0;
    fin        = 1'b0;
    sy_t       = sy_q;
    dly_t      = dly_q;
    dec_t      = dec_q;

    if (start) begin
      ctr_x_d    = center_x_i;
      ctr_y_d    = center_y_i;
      rad_d      = radius_i;
      tot_d      = (thickness_i == '0) ? THICK_W'(1) : thickness_i;
      col_d      = color_i;
      idx_d      = '0;
      busy_d     = 1'b1;
      begin_ring = 1'b1;
    end else if (!busy_q) begin
      fin = 1'b1;
    end else if (sx_q < sy_q) begin
      do_step = 1'b1;
    end else if (more_rings) begin
      idx_d      = idx_q + THICK_W'(1);
      begin_ring = 1'b1;
    end else begin
      busy_d = 1'b0;
      fin    = 1'b1;
    end

    cx  = AW'($signed(ctr_x_d));
    cy  = AW'($signed(ctr_y_d));
    r_w = $signed(AW'(rad_d)) - $signed(AW'(idx_d));

    off_a = '0;
    off_b = '0;
    en    = '0;
    if (begin_ring) begin
      dec_d = DW'(1) - DW'(r_w);
      dlx_d = AW'(1);
      dly_d = AW'(0) - (r_w + r_w);
      sx_d  = '0;
      sy_d  = r_w;
      off_b = r_w;
      en    = RING_AXIS_MASK;
    end else if (do_step) begin
      // step y inward when the midpoint lies outside the circle
      if (dec_q >= 0) begin
        sy_t  = sy_q - AW'(1);
        dly_t = dly_q + AW'(2);
        dec_t = dec_q + DW'(dly_t);
      end
      sy_d  = sy_t;
      dly_d = dly_t;
      sx_d  = sx_q + AW'(1);
      dlx_d = dlx_q + AW'(2);
      dec_d = dec_t + DW'(dlx_d);
      off_a = sx_d;
      off_b = sy_d;
      en    = '1;
    end

    xs[0] = cx + off_a;  ys[0] = cy + off_b;
    xs[1] = cx - off_a;  ys[1] = cy + off_b;
    xs[2] = cx + off_a;  ys[2] = cy - off_b;
    xs[3] = cx - off_a;  ys[3] = cy - off_b;
    xs[4] = cx + off_b;  ys[4] = cy + off_a;
    xs[5] = cx - off_b;  ys[5] = cy + off_a;
    xs[6] = cx + off_b;  ys[6] = cy - off_a;
    xs[7] = cx - off_b;  ys[7] = cy - off_a;

    for (int i = 0; i < NPIX; i++) begin
      vis[i] = !xs[i][AW-1] && ($unsigned(xs[i]) < AW'(scr_w_i)) &&
               !ys[i][AW-1] && ($unsigned(ys[i]) < AW'(scr_h_i));
      px_o[i] = xs[i][CW-1:0];
      py_o[i] = ys[i][CW-1:0];
    end

    burst_o.mask = en & vis;
    burst_o.fin  = fin;
    color_o      = col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q <= '0;
      ctr_y_q <= '0;
      rad_q   <= '0;
      idx_q   <= '0;
      tot_q   <= THICK_W'(1);
      sx_q    <= '0;
      sy_q    <= '0;
      dec_q   <= '0;
      dlx_q   <= AW'(1);
      dly_q   <= '0;
      busy_q  <= 1'b0;
      col_q   <= '0;
    end else if (take_i) begin
      ctr_x_q <= ctr_x_d;
      ctr_y_q <= ctr_y_d;
      rad_q   <= rad_d;
      idx_q   <= idx_d;
      tot_q   <= tot_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      dec_q   <= dec_d;
      dlx_q   <= dlx_d;
      dly_q   <= dly_d;
      busy_q  <= busy_d;
      col_q   <= col_d;
    end
  end

endmodule : tmcr_engine

`default_nettype wire

>>> rtl/core/tmcr_emit.sv
// Burst register for one word's surviving pixels and the output register
// that hands them out one per cycle unless stalled. Depends on tmcr_pkg.
`default_nettype none

module tmcr_emit import tmcr_pkg::*; #(
  parameter int unsigned CW = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic [CW-1:0]      px_i [NPIX],
  input  wire logic [CW-1:0]      py_i [NPIX],
  input  wire tmcr_burst_t        burst_i,
  input  wire logic [COLOR_W-1:0] color_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CW-1:0]           pixel_x_o,
  output logic [CW-1:0]           pixel_y_o,
  output logic [COLOR_W-1:0]      pixel_color_o,
  output logic                    pixel_valid_o,
  output logic                    finished_o,
  output logic                    last_o
);

  logic                b_valid_q;
  tmcr_burst_t         b_q;
  logic [CW-1:0]       b_px_q [NPIX];
  logic [CW-1:0]       b_py_q [NPIX];
  logic [COLOR_W-1:0]  b_col_q;

  logic                o_valid_q, o_pv_q, o_fin_q, o_last_q;
  logic [CW-1:0]       o_x_q, o_y_q;
  logic [COLOR_W-1:0]  o_col_q;

  logic                any, sel_last, o_free, move, found;
  logic [NPIX-1:0]     mask_rest;
  logic [CW-1:0]       sel_x, sel_y;

  always_comb begin
    any       = |b_q.mask;
    mask_rest = b_q.mask & (b_q.mask - NPIX'(1));
    sel_last  = (mask_rest == '0);
    found     = 1'b0;
    sel_x     = '0;
    sel_y     = '0;
    for (int i = 0; i < NPIX; i++) begin
      if (b_q.mask[i] && !found) begin
        found = 1'b1;
        sel_x = b_px_q[i];
        sel_y = b_py_q[i];
      end
    end
    o_free = !o_valid_q || !out_stall_i;
    move   = b_valid_q && o_free;
    free_o = !b_valid_q || (move && sel_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_q       <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (take_i) begin
        b_valid_q <= 1'b1;
        b_q       <= burst_i;
      end else if (move) begin
        // drop the pixel just handed over
        if (sel_last) begin
          b_valid_q <= 1'b0;
        end else begin
          b_q.mask <= mask_rest;
        end
      end
      if (move) begin
        o_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      b_px_q  <= px_i;
      b_py_q  <= py_i;
      b_col_q <= color_i;
    end
    if (move) begin
      o_x_q    <= any ? sel_x : '0;
      o_y_q    <= any ? sel_y : '0;
      o_col_q  <= any ? b_col_q : '0;
      o_pv_q   <= any;
      o_fin_q  <= !any && b_q.fin;
      o_last_q <= sel_last;
    end
  end

  assign out_valid_o   = o_valid_q;
  assign pixel_x_o     = o_x_q;
  assign pixel_y_o     = o_y_q;
  assign pixel_color_o = o_col_q;
  assign pixel_valid_o = o_pv_q;
  assign finished_o    = o_fin_q;
  assign last_o        = o_last_q;

endmodule : tmcr_emit

`default_nettype wire

>>> rtl/core/thick_midpoint_circle_rasterizer.sv
// Top level of the thick midpoint circle rasterizer: screen size registers,
// circle engine and pixel emitter. Depends on tmcr_pkg, tmcr_engine, tmcr_emit.
//
//   channel | signals                                   | direction
//   input   | in_valid_i, in_stall_o, kind_i .. color_i | word in
//   output  | out_valid_o, out_stall_i, pixel_*_o, ...  | one pixel/marker out
//   config  | cfg_we_i, cfg_addr_i, cfg_wdata_i         | register write
//
// A word is computed in the cycle it is accepted; its pixels leave the single
// pixel port one per cycle unless the output stalls, so a word yields 1 to 8
// items (advance words up to 8, start and ring words up to 4, markers 1).
// The next word is taken in the cycle the previous word's last pixel moves on.
// Reset returns to idle with a 240 x 320 screen; output stalls back up to input.
`default_nettype none

module thick_midpoint_circle_rasterizer import tmcr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_addr_i,
  input  wire logic [((COORD_BITS > CFG_REG_W) ? COORD_BITS : CFG_REG_W)-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  kind_i,
  input  wire logic [COORD_BITS-1:0] center_x_i,
  input  wire logic [COORD_BITS-1:0] center_y_i,
  input  wire logic [RADIUS_W-1:0]   radius_i,
  input  wire logic [THICK_W-1:0]    thickness_i,
  input  wire logic [COLOR_W-1:0]    color_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [COORD_BITS-1:0]      pixel_x_o,
  output logic [COORD_BITS-1:0]      pixel_y_o,
  output logic [COLOR_W-1:0]         pixel_color_o,
  output logic                       pixel_valid_o,
  output logic                       finished_o,
  output logic                       last_o
);

  localparam int unsigned SW = (COORD_BITS > CFG_REG_W) ? COORD_BITS : CFG_REG_W;
  localparam int unsigned AW = ((COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W) + 3;
  localparam int unsigned DW = AW + 3;

  logic [SW-1:0]      scr_w_q, scr_h_q;
  logic               take, free;
  logic [COORD_BITS-1:0] px [NPIX];
  logic [COORD_BITS-1:0] py [NPIX];
  tmcr_burst_t        burst;
  logic [COLOR_W-1:0] color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= SW'(SCREEN_WIDTH_RESET);
      scr_h_q <= SW'(SCREEN_HEIGHT_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SCREEN_WIDTH:  scr_w_q <= SW'(cfg_wdata_i[COORD_BITS-1:0]);
        REG_SCREEN_HEIGHT: scr_h_q <= SW'(cfg_wdata_i[COORD_BITS-1:0]);
        default: ;
      endcase
    end
  end

  assign take       = in_valid_i && free;
  assign in_stall_o = !free;

  tmcr_engine #(
    .CW(COORD_BITS),
    .AW(AW),
    .DW(DW),
    .SW(SW)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .kind_i     (kind_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .thickness_i(thickness_i),
    .color_i    (color_i),
    .scr_w_i    (scr_w_q),
    .scr_h_i    (scr_h_q),
    .px_o       (px),
    .py_o       (py),
    .burst_o    (burst),
    .color_o    (color)
  );

  tmcr_emit #(
    .CW(COORD_BITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .px_i         (px),
    .py_i         (py),
    .burst_i      (burst),
    .color_i      (color),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .pixel_valid_o(pixel_valid_o),
    .finished_o   (finished_o),
    .last_o       (last_o)
  );

endmodule : thick_midpoint_circle_rasterizer

`default_nettype wire

>>> rtl/core/tmcr_checker.sv
// Port-level checks for the thick midpoint circle rasterizer, bound to the
// top level. Depends on tmcr_pkg.
`default_nettype none

module tmcr_checker import tmcr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [COORD_BITS-1:0] pixel_x_o,
  input wire logic [COORD_BITS-1:0] pixel_y_o,
  input wire logic [COLOR_W-1:0]    pixel_color_o,
  input wire logic                  pixel_valid_o,
  input wire logic                  finished_o,
  input wire logic                  last_o
);

  // held word stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_x_o) && $stable(pixel_y_o) &&
      $stable(pixel_color_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // finished marker always closes its input word and carries no pixel
  a_fin_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> last_o && !pixel_valid_o)
    else $error("finished flag on a pixel or a non-final word");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |->
      pixel_x_o == '0 && pixel_y_o == '0 && pixel_color_o == '0 && last_o)
    else $error("marker carries pixel data");

endmodule : tmcr_checker

bind thick_midpoint_circle_rasterizer tmcr_checker #(
  .COORD_BITS(COORD_BITS)
) u_tmcr_checker (.*);

`default_nettype wire
